@@ rtl/core/hsl2rgb_pkg.sv @@
// package: widths, payload types and hue curve helper for the hsl to rgb converter
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IN_W      = FRAC_BITS + 1;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;
  localparam int THIRD     = ONE / 3;

  // signed hue position after the third offset
  localparam int POS_W  = FRAC_BITS + 3;
  // six times a wrapped hue position
  localparam int SIX_W  = FRAC_BITS + 4;
  localparam int FAC_W  = FRAC_BITS + 1;
  localparam int PROD_W = 2 * IN_W + 1;
  localparam int LVL_W  = FRAC_BITS + 6;
  localparam int MUL_W  = LVL_W + FAC_W + 1;
  localparam int SCL_W  = LVL_W + 9;
  localparam int BYTE_W = 8;

  localparam logic signed [POS_W-1:0] ONE_POS   = POS_W'(ONE);
  localparam logic signed [POS_W-1:0] THIRD_POS = POS_W'(THIRD);

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  typedef struct packed {
    seg_e             seg;
    logic [FAC_W-1:0] factor;
  } hue_pt_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] v1;
    logic signed [LVL_W-1:0] v2;
    logic signed [LVL_W-1:0] d;
  } lvl_t;

  typedef struct packed {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_out_t;

  // wrap a hue position once and pick its curve segment and slope factor
  function automatic hue_pt_t hue_point(input logic signed [POS_W-1:0] pos);
    logic signed [POS_W-1:0] p;
    logic [FAC_W-1:0]        w;
    logic [SIX_W-1:0]        six;
    hue_pt_t                 r;
    p = pos;
    if (p < 0) p = p + ONE_POS;
    if (p > ONE_POS) p = p - ONE_POS;
    w   = p[FAC_W-1:0];
    six = (SIX_W'(w) << 2) + (SIX_W'(w) << 1);
    if (six < SIX_W'(ONE)) begin
      r.seg    = SEG_RISE;
      r.factor = six[FAC_W-1:0];
    end else if ((SIX_W'(w) << 1) < SIX_W'(ONE)) begin
      r.seg    = SEG_HIGH;
      r.factor = '0;
    end else if ((SIX_W'(w) << 1) + SIX_W'(w) < SIX_W'(2 * ONE)) begin
      r.seg    = SEG_FALL;
      r.factor = FAC_W'(SIX_W'(4 * ONE) - six);
    end else begin
      r.seg    = SEG_LOW;
      r.factor = '0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/hsl_to_rgb8.sv @@
// hsl to 8-bit rgb converter, five register stages
// throughput: one request per cycle; the whole pipe holds when the output stalls
// the limit is one product per stage: lightness-saturation product, then slope product
// reset clears the stage valid bits only; data registers are not reset
`timescale 1ns / 1ps

module hsl_to_rgb8 (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hsl2rgb_pkg::hsl_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsl2rgb_pkg::rgb_out_t  out_data_o
);

  localparam int NStages = 5;

  logic [NStages-1:0]          valid_q;
  logic [NStages-1:0]          valid_d;
  logic                        en;
  hsl2rgb_pkg::hue_pt_t [2:0]  pt;
  hsl2rgb_pkg::lvl_t           lvl;

  // global advance: move whenever the last stage is empty or drained
  assign en         = !valid_q[NStages-1] || out_ready_i;
  assign in_ready_o = en;
  assign valid_d    = {valid_q[NStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  hsl2rgb_hue u_hue (
    .clk_i (clk_i),
    .en_i  (en),
    .hue_i (in_data_i.hue),
    .pt_o  (pt)
  );

  hsl2rgb_levels u_levels (
    .clk_i   (clk_i),
    .en_i    (en),
    .sat_i   (in_data_i.saturation),
    .light_i (in_data_i.lightness),
    .lvl_o   (lvl)
  );

  hsl2rgb_chan u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .pt_i   (pt[2]),
    .lvl_i  (lvl),
    .byte_o (out_data_o.red)
  );

  hsl2rgb_chan u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .pt_i   (pt[1]),
    .lvl_i  (lvl),
    .byte_o (out_data_o.green)
  );

  hsl2rgb_chan u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .pt_i   (pt[0]),
    .lvl_i  (lvl),
    .byte_o (out_data_o.blue)
  );

  assign out_valid_o = valid_q[NStages-1];

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted request did not enter the first stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("stage valid bits moved during a stall");

  a_factor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (pt[0].factor <= hsl2rgb_pkg::FAC_W'(hsl2rgb_pkg::ONE))
                && (pt[1].factor <= hsl2rgb_pkg::FAC_W'(hsl2rgb_pkg::ONE))
                && (pt[2].factor <= hsl2rgb_pkg::FAC_W'(hsl2rgb_pkg::ONE)))
    else $error("hue slope factor above one");

endmodule

@@ rtl/core/hsl2rgb_hue.sv @@
// hue positions for the three channels, segment decode, two register stages
`timescale 1ns / 1ps

module hsl2rgb_hue (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]          hue_i,
  output hsl2rgb_pkg::hue_pt_t [2:0]            pt_o
);

  logic signed [hsl2rgb_pkg::POS_W-1:0] base;
  hsl2rgb_pkg::hue_pt_t [2:0]           pt_d;
  hsl2rgb_pkg::hue_pt_t [2:0]           pt_q;
  hsl2rgb_pkg::hue_pt_t [2:0]           pt2_q;

  // red leads by a third, blue trails by a third
  always_comb begin
    base    = $signed({2'b00, hue_i});
    pt_d[2] = hsl2rgb_pkg::hue_point(base + hsl2rgb_pkg::THIRD_POS);
    pt_d[1] = hsl2rgb_pkg::hue_point(base);
    pt_d[0] = hsl2rgb_pkg::hue_point(base - hsl2rgb_pkg::THIRD_POS);
  end

  // second stage waits for the curve levels
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q  <= pt_d;
      pt2_q <= pt_q;
    end
  end

  assign pt_o = pt2_q;

endmodule

@@ rtl/core/hsl2rgb_levels.sv @@
// curve levels v1, v2 and their difference from saturation and lightness
`timescale 1ns / 1ps

module hsl2rgb_levels (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]   sat_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]   light_i,
  output hsl2rgb_pkg::lvl_t              lvl_o
);

  logic                                      lo;
  logic [hsl2rgb_pkg::IN_W:0]                ma;
  logic [hsl2rgb_pkg::IN_W:0]                mb;
  logic [hsl2rgb_pkg::PROD_W-1:0]            prod_d;
  logic [hsl2rgb_pkg::PROD_W-1:0]            prod_q;
  logic [hsl2rgb_pkg::IN_W-1:0]              l_q;
  logic [hsl2rgb_pkg::IN_W-1:0]              s_q;
  logic                                      lo_q;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]      pq_s;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]      l_s;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]      s_s;
  hsl2rgb_pkg::lvl_t                         lvl_d;
  hsl2rgb_pkg::lvl_t                         lvl_q;

  // one shared product: l*(one+s) below half, s*l otherwise
  always_comb begin
    lo     = light_i < hsl2rgb_pkg::IN_W'(hsl2rgb_pkg::HALF);
    ma     = lo ? {1'b0, light_i} : {1'b0, sat_i};
    mb     = lo ? ((hsl2rgb_pkg::IN_W + 1)'(hsl2rgb_pkg::ONE) + {1'b0, sat_i})
                : {1'b0, light_i};
    prod_d = hsl2rgb_pkg::PROD_W'(ma) * hsl2rgb_pkg::PROD_W'(mb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      l_q    <= light_i;
      s_q    <= sat_i;
      lo_q   <= lo;
    end
  end

  always_comb begin
    pq_s = hsl2rgb_pkg::LVL_W'(prod_q[hsl2rgb_pkg::PROD_W-1:hsl2rgb_pkg::FRAC_BITS]);
    l_s  = hsl2rgb_pkg::LVL_W'(l_q);
    s_s  = hsl2rgb_pkg::LVL_W'(s_q);
    lvl_d.v2 = lo_q ? pq_s : (l_s + s_s - pq_s);
    lvl_d.v1 = (l_s <<< 1) - lvl_d.v2;
    lvl_d.d  = lvl_d.v2 - lvl_d.v1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lvl_q <= lvl_d;
    end
  end

  assign lvl_o = lvl_q;

endmodule

@@ rtl/core/hsl2rgb_chan.sv @@
// one output channel: slope multiply, segment select, scale by 255 and clamp
`timescale 1ns / 1ps

module hsl2rgb_chan (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  hsl2rgb_pkg::hue_pt_t              pt_i,
  input  hsl2rgb_pkg::lvl_t                 lvl_i,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]    byte_o
);

  localparam logic signed [hsl2rgb_pkg::SCL_W-1:0] ByteTop = hsl2rgb_pkg::SCL_W'(255);

  logic signed [hsl2rgb_pkg::MUL_W-1:0]  m_d;
  logic signed [hsl2rgb_pkg::MUL_W-1:0]  m_q;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]  v1_q;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]  v2_q;
  hsl2rgb_pkg::seg_e                     seg_q;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]  c_d;
  logic signed [hsl2rgb_pkg::LVL_W-1:0]  c_q;
  logic signed [hsl2rgb_pkg::SCL_W-1:0]  x;
  logic signed [hsl2rgb_pkg::SCL_W-1:0]  y;
  logic [hsl2rgb_pkg::BYTE_W-1:0]        byte_d;
  logic [hsl2rgb_pkg::BYTE_W-1:0]        byte_q;

  assign m_d = hsl2rgb_pkg::MUL_W'(lvl_i.d)
             * hsl2rgb_pkg::MUL_W'($signed({1'b0, pt_i.factor}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= m_d;
      v1_q  <= lvl_i.v1;
      v2_q  <= lvl_i.v2;
      seg_q <= pt_i.seg;
    end
  end

  // arithmetic shift gives the floor of the product over one
  always_comb begin
    case (seg_q)
      hsl2rgb_pkg::SEG_RISE,
      hsl2rgb_pkg::SEG_FALL: c_d = v1_q + hsl2rgb_pkg::LVL_W'(m_q >>> hsl2rgb_pkg::FRAC_BITS);
      hsl2rgb_pkg::SEG_HIGH: c_d = v2_q;
      default:               c_d = v1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  // times 255 as shift and subtract
  always_comb begin
    x = (hsl2rgb_pkg::SCL_W'(c_q) <<< 8) - hsl2rgb_pkg::SCL_W'(c_q);
    y = x >>> hsl2rgb_pkg::FRAC_BITS;
    if (y < 0) begin
      byte_d = '0;
    end else if (y > ByteTop) begin
      byte_d = '1;
    end else begin
      byte_d = y[hsl2rgb_pkg::BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule
